FILE: hw/rtl/tma_pkg.sv
// shared widths, defaults, register indexes, range codes and the divider status type for the trimmed mean averager
package tma_pkg;

    localparam int CODE_W        = 16;
    localparam int SAMPLE_W      = 29;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE_SEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEN     = 2'd1;

    localparam logic [2:0] FSS_RESET = 3'd1;
    localparam logic [4:0] WLEN_RESET = 5'd10;
    localparam logic [4:0] WLEN_MIN   = 5'd3;

    localparam logic [2:0] RNG_6144 = 3'd0;
    localparam logic [2:0] RNG_4096 = 3'd1;
    localparam logic [2:0] RNG_2048 = 3'd2;
    localparam logic [2:0] RNG_1024 = 3'd3;
    localparam logic [2:0] RNG_512  = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: hw/rtl/trimmed_mean_adc_averager_unit.sv
// trimmed mean averager top level: serial sum and extreme tracking, serial divide at window close
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[15:0] raw_code
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[28:0] average_scaled, tuser[0] window_done
//  cfg       in   cfg_valid/cfg_ready          cfg_index register, cfg_data value
//
//  an item is taken in idle, shifted SUM_W bits through the one-bit serial adder and comparators,
//  then updated and output; a window-closing item also trims, starts and waits for the serial divider
//  reset leaves no clearing pass; cfg_ready is always high
//  a waiting result sits in the output register; the core stalls only when it is still full
module trimmed_mean_adc_averager_unit
    import tma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [15:0]            s_axis_tdata,   // raw_code
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // average_scaled[28:0], zero pad
    output logic [0:0]             m_axis_tuser,   // window_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SumW   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int CntW   = $clog2(SumW);
    localparam int LenW   = $clog2(MAX_WINDOW + 1);
    localparam int RstLen = (int'(WLEN_RESET) > MAX_WINDOW) ? MAX_WINDOW : int'(WLEN_RESET);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SER   = 8'b0000_0010,
        S_UPD   = 8'b0000_0100,
        S_TRIM1 = 8'b0000_1000,
        S_TRIM2 = 8'b0001_0000,
        S_DIVGO = 8'b0010_0000,
        S_DIVW  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                state_reg;
    logic [2:0]            fss_reg;
    logic [4:0]            wlen_reg;
    logic [LenW-1:0]       left_reg;
    logic                  empty_reg;
    logic [CntW-1:0]       cnt_reg;
    logic                  cy_reg;
    logic                  gt_reg;
    logic                  lt_reg;
    logic [SumW-1:0]       smp_reg;
    logic [SumW-1:0]       sum_reg;
    logic [SAMPLE_W-1:0]   max_reg;
    logic [SAMPLE_W-1:0]   min_reg;
    logic [SumW-1:0]       trim_reg;
    logic [SAMPLE_W-1:0]   held_reg;
    logic                  close_reg;
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_avg_reg;
    logic                  out_done_reg;

    logic [LenW-1:0]       eff_len;
    logic [LenW-1:0]       left_next;
    logic                  gt_next;
    logic                  lt_next;
    logic                  sum_bit;
    logic                  cy_next;
    logic                  cmp_on;
    logic                  sign_pos;
    logic [SAMPLE_W-1:0]   scaled;
    logic                  div_start;
    logic [SumW-1:0]       div_quo;
    div_sts_t              div_sts;

    function automatic logic [SAMPLE_W-1:0] scale_code(input logic [CODE_W-1:0] code,
                                                       input logic [2:0] sel);
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] r;
        x = {{(SAMPLE_W-CODE_W){code[CODE_W-1]}}, code};
        case (sel)
            RNG_6144: r = (x << 12) + (x << 11);
            RNG_4096: r = x << 12;
            RNG_2048: r = x << 11;
            RNG_1024: r = x << 10;
            RNG_512:  r = x << 9;
            default:  r = x << 8;
        endcase
        return r;
    endfunction

    always_comb
    begin
        if (wlen_reg < WLEN_MIN)
        begin
            eff_len = LenW'(int'(WLEN_MIN));
        end
        else if (int'(wlen_reg) > MAX_WINDOW)
        begin
            eff_len = LenW'(MAX_WINDOW);
        end
        else
        begin
            eff_len = LenW'(wlen_reg);
        end
    end

    // serial datapath, lsb first
    always_comb
    begin
        scaled   = scale_code(s_axis_tdata, fss_reg);
        cmp_on   = cnt_reg < CntW'(SAMPLE_W);
        sign_pos = cnt_reg == CntW'(SAMPLE_W - 1);
        sum_bit  = sum_reg[0] ^ smp_reg[0] ^ cy_reg;
        cy_next  = (sum_reg[0] & smp_reg[0]) | (cy_reg & (sum_reg[0] ^ smp_reg[0]));
        gt_next  = gt_reg;
        lt_next  = lt_reg;
        if (cmp_on && (smp_reg[0] != max_reg[0]))
        begin
            gt_next = sign_pos ? max_reg[0] : smp_reg[0];
        end
        if (cmp_on && (smp_reg[0] != min_reg[0]))
        begin
            lt_next = sign_pos ? smp_reg[0] : min_reg[0];
        end
        left_next = (left_reg != '0) ? (left_reg - 1'b1) : left_reg;
    end

    assign div_start = (state_reg == S_DIVGO);

    tma_sdiv #(
        .NumW (SumW),
        .DenW (LenW)
    ) u_sdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (trim_reg),
        .divisor  (eff_len - LenW'(2)),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fss_reg       <= FSS_RESET;
            wlen_reg      <= WLEN_RESET;
            left_reg      <= LenW'(RstLen);
            empty_reg     <= 1'b1;
            cnt_reg       <= '0;
            cy_reg        <= 1'b0;
            gt_reg        <= 1'b0;
            lt_reg        <= 1'b0;
            smp_reg       <= '0;
            sum_reg       <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            trim_reg      <= '0;
            held_reg      <= '0;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_avg_reg   <= '0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        smp_reg   <= {{(SumW-SAMPLE_W){scaled[SAMPLE_W-1]}}, scaled};
                        cnt_reg   <= '0;
                        cy_reg    <= 1'b0;
                        gt_reg    <= 1'b0;
                        lt_reg    <= 1'b0;
                        state_reg <= S_SER;
                    end
                end
                S_SER:
                begin
                    smp_reg <= {smp_reg[0], smp_reg[SumW-1:1]};
                    sum_reg <= {sum_bit, sum_reg[SumW-1:1]};
                    cy_reg  <= cy_next;
                    gt_reg  <= gt_next;
                    lt_reg  <= lt_next;
                    if (cmp_on)
                    begin
                        max_reg <= {max_reg[0], max_reg[SAMPLE_W-1:1]};
                        min_reg <= {min_reg[0], min_reg[SAMPLE_W-1:1]};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CntW'(SumW - 1))
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (empty_reg || gt_reg)
                    begin
                        max_reg <= smp_reg[SAMPLE_W-1:0];
                    end
                    if (empty_reg || lt_reg)
                    begin
                        min_reg <= smp_reg[SAMPLE_W-1:0];
                    end
                    empty_reg <= 1'b0;
                    left_reg  <= left_next;
                    close_reg <= (left_next == '0);
                    state_reg <= (left_next == '0) ? S_TRIM1 : S_OUT;
                end
                S_TRIM1:
                begin
                    trim_reg  <= sum_reg - {{(SumW-SAMPLE_W){max_reg[SAMPLE_W-1]}}, max_reg};
                    state_reg <= S_TRIM2;
                end
                S_TRIM2:
                begin
                    trim_reg  <= trim_reg - {{(SumW-SAMPLE_W){min_reg[SAMPLE_W-1]}}, min_reg};
                    state_reg <= S_DIVGO;
                end
                S_DIVGO:
                begin
                    // window restart
                    sum_reg   <= '0;
                    empty_reg <= 1'b1;
                    left_reg  <= eff_len;
                    state_reg <= S_DIVW;
                end
                S_DIVW:
                begin
                    if (div_sts.done)
                    begin
                        held_reg  <= div_quo[SAMPLE_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_avg_reg   <= held_reg;
                        out_done_reg  <= close_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_FULL_SCALE_SEL:
                    begin
                        fss_reg <= cfg_data[2:0];
                    end
                    REG_WINDOW_LEN:
                    begin
                        wlen_reg  <= cfg_data;
                        sum_reg   <= '0;
                        empty_reg <= 1'b1;
                        // reload from the new length
                        if (cfg_data < WLEN_MIN)
                        begin
                            left_reg <= LenW'(int'(WLEN_MIN));
                        end
                        else if (int'(cfg_data) > MAX_WINDOW)
                        begin
                            left_reg <= LenW'(MAX_WINDOW);
                        end
                        else
                        begin
                            left_reg <= LenW'(cfg_data);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32-SAMPLE_W){1'b0}}, out_avg_reg};
    assign m_axis_tuser  = out_done_reg;

`ifndef SYNTHESIS
    a_accept_starts_serial: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_SER)
        else $error("accepted word did not start the serial pass");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == S_DIVW)
        else $error("divider finished outside the wait state");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_sts.busy)
        else $error("divider busy while core idle");

    a_idle_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> left_reg != '0)
        else $error("sample countdown empty while idle");
`endif

endmodule

FILE: hw/rtl/tma_sdiv.sv
// bit-serial restoring divider, signed dividend by small unsigned divisor, truncating toward zero
module tma_sdiv
    import tma_pkg::*;
#(
    parameter int NumW = 33,
    parameter int DenW = 5
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NumW-1:0] dividend,
    input  logic [DenW-1:0] divisor,
    output div_sts_t        sts,
    output logic [NumW-1:0] quotient
);

    localparam int CntW = $clog2(NumW);

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_FIX  = 3'b100
    } dstate_t;

    dstate_t          state_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [NumW-1:0]  quo_reg;
    logic [DenW-1:0]  rem_reg;
    logic [DenW-1:0]  den_reg;

    logic [DenW:0]    shifted;
    logic [DenW:0]    diff;
    logic             fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[NumW-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
        end
        else
        begin
            done_reg <= (state_reg == D_FIX);
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg   <= dividend[NumW-1];
                        quo_reg   <= dividend[NumW-1] ? (~dividend + 1'b1) : dividend;
                        den_reg   <= divisor;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? diff[DenW-1:0] : shifted[DenW-1:0];
                    quo_reg <= {quo_reg[NumW-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CntW'(NumW - 1))
                    begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    quo_reg   <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign sts      = {(state_reg != D_IDLE), done_reg};
    assign quotient = quo_reg;

endmodule
